// ===== hdl/kcs_pkg.sv =====
// ----------------------------------------------------------------------------
// kcs_pkg: shared types and constants for the k-mer count and score block
// Beat payloads, fixed field widths and the reset value of the k register.
// ----------------------------------------------------------------------------
package kcs_pkg;

   // fixed field widths
   localparam int CFG_W   = 4;
   localparam int SUM_W   = 37;
   localparam int LEN_W   = 32;
   localparam int NRC_W   = 20;
   localparam int FRAC_W  = 16;
   // quotient bits above the fraction point
   localparam int INT_W   = NRC_W - FRAC_W;

   localparam int MAX_K_DEFAULT      = 10;
   localparam int COUNT_BITS_DEFAULT = 20;

   localparam logic [CFG_W-1:0] KMER_LEN_RESET = 4'd10;

   localparam logic ACT_TRAIN = 1'b0;
   localparam logic ACT_SCORE = 1'b1;

   typedef struct packed {
      logic       action;
      logic [1:0] base;
      logic       seq_last;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] score_bits;
      logic [LEN_W-1:0] base_count;
      logic [NRC_W-1:0] nrc_fixed;
   } rsp_type;

   // count table access command
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tbl_cmd_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== hdl/kcs_table.sv =====
// ----------------------------------------------------------------------------
// kcs_table: k-mer count memory
// Single write port, one registered read port, zeroing sweep after reset.
// ----------------------------------------------------------------------------
module kcs_table #(
   parameter int ADDR_W = 20,
   parameter int DATA_W = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kcs_pkg::tbl_cmd_type cmd,
   input  logic [ADDR_W-1:0]    addr,
   input  logic [DATA_W-1:0]    wr_data,
   output logic [DATA_W-1:0]    rd_data,
   output logic                 clearing
);
   import kcs_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;

   // sweep every entry once after reset, one per cycle
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {ADDR_W{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign mem_we    = clr_busy_ff | cmd.wr_en;
   assign mem_waddr = clr_busy_ff ? clr_addr_ff : addr;
   assign mem_wdata = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule

// ===== hdl/kcs_div.sv =====
// ----------------------------------------------------------------------------
// kcs_div: score over twice length, restoring divider
// One quotient bit per cycle through a single subtractor; saturates early.
// ----------------------------------------------------------------------------
module kcs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [kcs_pkg::SUM_W-1:0]  sum,
   input  logic [kcs_pkg::LEN_W-1:0]  len,
   output logic [kcs_pkg::NRC_W-1:0]  quot,
   output kcs_pkg::div_stat_type      stat
);
   import kcs_pkg::*;

   localparam int DEN_W = LEN_W + 1;
   localparam int REM_W = DEN_W + 1;
   localparam int CNT_W = $clog2(NRC_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [NRC_W-1:0] num_ff, num_in;
   logic [NRC_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [REM_W-1:0] trial;
   logic [REM_W:0]   diff;
   logic             sat;

   // quotient reaches 2^NRC_W exactly when sum >= len * 2^(INT_W+1)
   assign sat   = sum >= {len, {(INT_W + 1){1'b0}}};
   assign trial = {rem_ff[REM_W-2:0], num_ff[NRC_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      if (start) begin
         done_in = 1'b0;
         den_in  = {len, 1'b0};
         num_in  = {sum[INT_W-1:0], {FRAC_W{1'b0}}};
         rem_in  = {1'b0, sum[SUM_W-1:INT_W]};
         cnt_in  = CNT_W'(NRC_W);
         if (sat) begin
            quot_in = '1;
            done_in = 1'b1;
         end else begin
            quot_in = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         // shift in the next numerator bit, subtract where it fits
         if (!diff[REM_W]) begin
            rem_in  = diff[REM_W-1:0];
            quot_in = {quot_ff[NRC_W-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NRC_W-2:0], 1'b0};
         end
         num_in = {num_ff[NRC_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign quot      = quot_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== hdl/kmer_count_and_score.sv =====
// A train beat passes through the read and update steps before ready returns; a score
// beat also takes the log step, a one-bit-per-cycle shifter, and the accumulate step.
// A scored sequence end adds the divider start, wait and output steps; the restoring
// divider gives one quotient bit a cycle and ends early when the ratio saturates.
// One beat is in work at a time. After reset the count table is swept to zero with
// req_ready low; csr writes are taken throughout.
// ----------------------------------------------------------------------------
// kmer_count_and_score: k-mer counting and scoring of DNA base streams
// Trains a saturating k-mer count table and scores sequences against it.
// ----------------------------------------------------------------------------
module kmer_count_and_score #(
   parameter int MAX_K      = kcs_pkg::MAX_K_DEFAULT,
   parameter int COUNT_BITS = kcs_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  kcs_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output kcs_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [kcs_pkg::CFG_W-1:0] csr_data
);
   import kcs_pkg::*;

   localparam int WIN_W  = 2 * MAX_K;
   localparam int FILL_W = $clog2(MAX_K + 1);
   localparam int LG_W   = $clog2(COUNT_BITS + 1);

   // sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_UPD    = 3'd2;
   localparam logic [2:0] ST_LOG    = 3'd3;
   localparam logic [2:0] ST_ACC    = 3'd4;
   localparam logic [2:0] ST_DSTART = 3'd5;
   localparam logic [2:0] ST_DWAIT  = 3'd6;
   localparam logic [2:0] ST_OUT    = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CFG_W-1:0]      kmer_len_ff;
   logic [CFG_W-1:0]      k_eff;
   logic [WIN_W-1:0]      win_ff, win_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [WIN_W-1:0]      idx_ff, idx_in;
   logic                  full_ff, full_in;
   logic                  act_ff, act_in;
   logic                  last_ff, last_in;
   logic [COUNT_BITS:0]   lg_val_ff, lg_val_in;
   logic [LG_W-1:0]       lg_cnt_ff, lg_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [WIN_W+1:0]      win_shift;
   logic [FILL_W-1:0]     fill_next;
   logic [WIN_W-1:0]      k_mask;
   logic [SUM_W:0]        sum_add;
   logic                  req_fire;
   logic                  seq_end;

   tbl_cmd_type           tbl_cmd;
   logic [COUNT_BITS-1:0] tbl_rd_data;
   logic [COUNT_BITS-1:0] tbl_wr_data;
   logic                  tbl_clearing;

   logic                  div_start;
   logic [NRC_W-1:0]      div_quot;
   div_stat_type          div_stat;

   kcs_table #(
      .ADDR_W (WIN_W),
      .DATA_W (COUNT_BITS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .addr     (idx_ff),
      .wr_data  (tbl_wr_data),
      .rd_data  (tbl_rd_data),
      .clearing (tbl_clearing)
   );

   kcs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (sum_ff),
      .len   (len_ff),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   // ---- configuration: one register, always writable --------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff <= KMER_LEN_RESET;
      end else if (csr_valid) begin
         kmer_len_ff <= csr_data;
      end
   end

   // clamp k into 1..MAX_K
   always_comb begin
      k_eff = kmer_len_ff;
      if (kmer_len_ff == '0) begin
         k_eff = CFG_W'(1);
      end else if (kmer_len_ff > CFG_W'(MAX_K)) begin
         k_eff = CFG_W'(MAX_K);
      end
   end

   // two mask bits per base lane, set for the k newest lanes
   always_comb begin
      for (int i = 0; i < MAX_K; i++) begin
         k_mask[2*i +: 2] = (CFG_W'(i) < k_eff) ? 2'b11 : 2'b00;
      end
   end

   // ---- beat acceptance: shift the window and latch the table index ------
   assign req_ready = (state_ff == ST_IDLE) && !tbl_clearing;
   assign req_fire  = req_valid && req_ready;

   // newest base goes in the low two bits; the oldest drops off the top
   assign win_shift = {win_ff, req_data.base};
   assign fill_next = (fill_ff < FILL_W'(MAX_K)) ? fill_ff + 1'b1 : fill_ff;

   // the table read data and the rest of the work share one pass through
   // a small sequencer; each state drives one step
   assign tbl_wr_data = tbl_rd_data + 1'b1;
   assign sum_add     = {1'b0, sum_ff} + (SUM_W + 1)'(lg_cnt_ff);

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      full_in      = full_ff;
      act_in       = act_ff;
      last_in      = last_ff;
      lg_val_in    = lg_val_ff;
      lg_cnt_in    = lg_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      tbl_cmd      = '0;
      div_start    = 1'b0;
      seq_end      = 1'b0;

      // drop the result once the consumer takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               win_in   = win_shift[WIN_W-1:0];
               fill_in  = fill_next;
               idx_in   = win_shift[WIN_W-1:0] & k_mask;
               full_in  = CFG_W'(fill_next) >= k_eff;
               act_in   = req_data.action;
               last_in  = req_data.seq_last;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            tbl_cmd.rd_en = 1'b1;
            state_in      = ST_UPD;
         end
         ST_UPD: begin
            if (act_ff == ACT_TRAIN) begin
               // saturating count bump for a full window
               tbl_cmd.wr_en = full_ff && (tbl_rd_data != {COUNT_BITS{1'b1}});
               seq_end       = last_ff;
               state_in      = ST_IDLE;
            end else begin
               if (len_ff != {LEN_W{1'b1}}) begin
                  len_in = len_ff + 1'b1;
               end
               // a window not yet full feeds a one, which logs to zero
               lg_val_in = full_ff ? {1'b0, tbl_rd_data} + 1'b1 : (COUNT_BITS + 1)'(1);
               lg_cnt_in = '0;
               state_in  = ST_LOG;
            end
         end
         ST_LOG: begin
            // one right shift per cycle until the value drops to one
            if (lg_val_ff > (COUNT_BITS + 1)'(1)) begin
               lg_val_in = lg_val_ff >> 1;
               lg_cnt_in = lg_cnt_ff + 1'b1;
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            sum_in   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
            state_in = last_ff ? ST_DSTART : ST_IDLE;
         end
         ST_DSTART: begin
            div_start = 1'b1;
            state_in  = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (div_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold here while the previous result still waits
            if (!rsp_valid_ff) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.score_bits = sum_ff;
               rsp_data_in.base_count = len_ff;
               rsp_data_in.nrc_fixed  = div_quot;
               seq_end                = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a sequence end empties the window and the running totals
      if (seq_end) begin
         win_in  = '0;
         fill_in = '0;
         sum_in  = '0;
         len_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      full_ff     <= full_in;
      act_ff      <= act_in;
      last_ff     <= last_in;
      lg_val_ff   <= lg_val_in;
      lg_cnt_ff   <= lg_cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a new result appears only out of the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output step");

   // table writes from the sequencer only in a train update
   a_wr_train: assert property (@(posedge clock) disable iff (reset)
      tbl_cmd.wr_en |-> (state_ff == ST_UPD) && (act_ff == ACT_TRAIN))
      else $error("count table written outside a train update");

   // the divider runs only while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DWAIT)
      else $error("divider busy outside the wait step");

   // window fill never passes the window size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_K))
      else $error("window fill beyond MAX_K");

   // no beat is taken during the table sweep
   a_no_beat_clr: assert property (@(posedge clock) disable iff (reset)
      tbl_clearing |-> !req_ready)
      else $error("beat accepted while the table is swept");
`endif

endmodule

// ===== tb/tb_kmer_count_and_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kmer_count_and_score: self-checking bench for the k-mer count and score block
// Streams trained and scored base sequences under several k settings, with
// random request gaps and result stalls, and checks every score beat against
// a cycle-free model of the count table and running sums.
// ----------------------------------------------------------------------------
module tb_kmer_count_and_score;
   import kcs_pkg::*;

   localparam int MAX_K       = MAX_K_DEFAULT;
   localparam int COUNT_BITS  = COUNT_BITS_DEFAULT;
   localparam int TABLE_DEPTH = 1 << (2 * MAX_K);
   // the table sweep after reset holds req_ready low while the whole table is zeroed,
   // so the watchdog must sit well above the sweep
   localparam int unsigned WATCHDOG_LIMIT = 4500000;
   // let a score beat and the divider run to the end before touching the
   // k register or closing the run
   localparam int unsigned SETTLE_CYCLES  = 64;
   localparam int unsigned PHASE_BASES    = 170;

   // -------------------------------------------------------------------------
   // scoreboard: mirrors the count table and sums, queues the expected beats
   // -------------------------------------------------------------------------
   class kmer_score_predictor;
      bit [CFG_W-1:0]      kmer_len;
      bit [2*MAX_K-1:0]    window;
      int unsigned         fill;
      bit [COUNT_BITS-1:0] counts [0:TABLE_DEPTH-1];
      bit [SUM_W-1:0]      score_sum;
      bit [LEN_W-1:0]      run_len;
      rsp_type             expected_scores [$];
      int unsigned         mismatches;
      int unsigned         scores_checked;

      function new();
         kmer_len  = KMER_LEN_RESET;
         window    = '0;
         fill      = 0;
         score_sum = '0;
         run_len   = '0;
      endfunction

      // note one accepted base and queue a score if it closes a scored sequence
      function void absorb_base(req_type b);
         int unsigned         k;
         int unsigned         lg;
         bit [2*MAX_K-1:0]    mask;
         bit [2*MAX_K-1:0]    idx;
         bit [COUNT_BITS-1:0] cnt;
         bit [63:0]           v;
         bit [SUM_W:0]        acc;
         bit [63:0]           num;
         bit [63:0]           den;
         bit [63:0]           quot;
         rsp_type             r;
         k = (kmer_len == 0) ? 1 : ((kmer_len > MAX_K) ? MAX_K : kmer_len);
         window = {window[2*MAX_K-3:0], b.base};
         if (fill < MAX_K) fill++;
         mask = {(2 * MAX_K){1'b1}} >> (2 * (MAX_K - k));
         idx  = window & mask;
         cnt  = counts[idx];
         if (b.action == ACT_TRAIN) begin
            if (fill >= k && cnt != '1) counts[idx] = cnt + 1'b1;
         end else begin
            if (run_len != '1) run_len++;
            if (fill >= k) begin
               v  = 64'(cnt);
               v  = v + 1;
               lg = 0;
               while (v > 1) begin
                  v = v >> 1;
                  lg++;
               end
               acc = score_sum + lg;
               score_sum = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
            end
            if (b.seq_last) begin
               num  = 64'(score_sum);
               num  = num << FRAC_W;
               den  = 64'(run_len);
               den  = den << 1;
               quot = num / den;
               r.score_bits = score_sum;
               r.base_count = run_len;
               r.nrc_fixed  = (quot > {NRC_W{1'b1}}) ? '1 : quot[NRC_W-1:0];
               expected_scores.push_back(r);
            end
         end
         if (b.seq_last) begin
            window    = '0;
            fill      = 0;
            score_sum = '0;
            run_len   = '0;
         end
      endfunction

      // compare one accepted score beat with the oldest expectation
      function void check_score(rsp_type got);
         rsp_type exp_beat;
         if (expected_scores.size() == 0) begin
            $display("%0t: unexpected score beat %h", $time, got);
            mismatches++;
            return;
         end
         exp_beat = expected_scores.pop_front();
         scores_checked++;
         if (got.score_bits !== exp_beat.score_bits) begin
            $display("%0t: score_bits mismatch, expected %0d, got %0d",
                     $time, exp_beat.score_bits, got.score_bits);
            mismatches++;
         end
         if (got.base_count !== exp_beat.base_count) begin
            $display("%0t: base_count mismatch, expected %0d, got %0d",
                     $time, exp_beat.base_count, got.base_count);
            mismatches++;
         end
         if (got.nrc_fixed !== exp_beat.nrc_fixed) begin
            $display("%0t: nrc_fixed mismatch, expected %0d, got %0d",
                     $time, exp_beat.nrc_fixed, got.nrc_fixed);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_scores.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and DUT
   // -------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data;

   kmer_score_predictor pred;
   bit                  steady;        // suppress gaps and stalls on both sides
   int unsigned         bases_sent;
   int unsigned         k_writes;
   int unsigned         idle_cycles;

   always #4 clock = ~clock;

   kmer_count_and_score u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // mostly no gap or a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // -------------------------------------------------------------------------
   // drivers: change inputs on the falling edge, sample on the rising edge
   // -------------------------------------------------------------------------

   // present one base beat, hold until taken, then maybe drop valid for a while
   task automatic send_base(input logic action, input logic [1:0] base, input logic last);
      req_type     b;
      int unsigned gap;
      b.action   = action;
      b.base     = base;
      b.seq_last = last;
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = b;
      do @(posedge clock); while (!req_ready);
      pred.absorb_base(b);
      bases_sent++;
      gap = steady ? 0 : pick_gap();
      if (gap != 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // drop valid so the last beat is not taken twice, wait for every score
   // beat, then let any train beat in flight finish
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pred.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_kmer_len(input logic [CFG_W-1:0] k);
      @(negedge clock);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_data  = k;
      do @(posedge clock); while (!csr_ready);
      pred.kmer_len = k;
      k_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // random sequences; most repeat a few short motifs so counts build up and
   // scores become non-trivial, the rest are random bases or mixed actions
   task automatic stream_bases(input int unsigned n);
      logic [1:0]  motif [0:3][0:5];
      int unsigned motif_len [0:3];
      int unsigned sent;
      int unsigned r;
      int unsigned len;
      int unsigned m;
      logic        act;
      logic        a;
      logic [1:0]  base;
      for (int i = 0; i < 4; i++) begin
         motif_len[i] = $urandom_range(1, 6);
         for (int j = 0; j < 6; j++) motif[i][j] = 2'($urandom_range(0, 3));
      end
      sent = 0;
      while (sent < n) begin
         r   = $urandom_range(0, 99);
         act = ($urandom_range(0, 99) < 55) ? ACT_TRAIN : ACT_SCORE;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
         m   = $urandom_range(0, 3);
         for (int i = 0; i < len && sent < n; i++) begin
            if (r < 70) begin
               base = motif[m][i % motif_len[m]];
               if ($urandom_range(0, 19) == 0) base = 2'($urandom_range(0, 3));
            end else begin
               base = 2'($urandom_range(0, 3));
            end
            a = (r >= 90) ? logic'($urandom_range(0, 1)) : act;
            send_base(a, base, i == len - 1);
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // result side: random stalls, check every accepted score beat
   // -------------------------------------------------------------------------
   initial begin
      int unsigned stall;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall != 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else begin
            rsp_ready = 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) pred.check_score(rsp_data);
   end

   // watchdog: count cycles in which no channel moves a beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [CFG_W-1:0] k_plan [0:8];
      pred        = new();
      steady      = 1'b0;
      bases_sent  = 0;
      k_writes    = 0;
      idle_cycles = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      // zero and values above MAX_K exercise the clamping of k
      k_plan = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd10, 4'd2, 4'd7, 4'd12, 4'd3};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part at the reset k of 10
      // a one-base scored sequence never fills the window: score zero
      send_base(ACT_SCORE, 2'd0, 1'b1);
      // twelve T bases train the all-T k-mer three times, and the end of a
      // train sequence gives no beat but empties the window
      for (int i = 0; i < 12; i++) send_base(ACT_TRAIN, 2'd3, i == 11);
      // eleven T bases score two full windows at floor(log2(4)) each
      for (int i = 0; i < 11; i++) send_base(ACT_SCORE, 2'd3, i == 10);

      // random phases, each under its own k; a phase may stop mid-sequence,
      // so the next k lands on a partly filled window
      foreach (k_plan[p]) begin
         drain();
         write_kmer_len(k_plan[p]);
         steady = (p % 3 == 2);
         stream_bases(PHASE_BASES);
      end

      @(negedge clock);
      req_valid = 1'b0;
      drain();

      $display("Run covered %0d bases and %0d score beats across %0d k register writes",
               bases_sent, pred.scores_checked, k_writes);
      $display("k took 0, 1, 2, 3, 4, 7, 10, 12 and 15, with train, score and mixed sequences");
      if (pred.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
